// File: rtl/clb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clb_pkg
// Command and status codes, field widths and bus widths for the line buffer.
// ----------------------------------------------------------------------------
package clb_pkg;

	localparam int CMD_W       = 3;
	localparam int CH_W        = 8;
	localparam int POS_W       = 8;
	localparam int LEN_W       = 9;
	localparam int ST_W        = 2;
	localparam int IN_TDATA_W  = 16;
	localparam int OUT_TDATA_W = 32;
	localparam int OUT_PAD_W   = OUT_TDATA_W - CH_W - 2 * LEN_W;

	typedef enum logic [CMD_W-1:0] {
		CMD_INSERT    = 3'd0,
		CMD_LEFT      = 3'd1,
		CMD_RIGHT     = 3'd2,
		CMD_BACKSPACE = 3'd3,
		CMD_READ      = 3'd4
	} cmd_t;

	typedef enum logic [ST_W-1:0] {
		ST_OK       = 2'd0,
		ST_FULL     = 2'd1,
		ST_PAST_END = 2'd2
	} status_t;

endpackage

// File: rtl/cursor_line_edit_buffer_top.sv
`timescale 1ns / 1ps
// A result word appears in the cycle after its command word is taken.
// Throughput: one command word per cycle while result words are taken; a result
// held back by the receiver stalls the command side until it goes.
// Single register stage: the indexed reads come through registered memory ports
// beside the result register, and both stack tops are held in registers of their own.
// Reset clears both counts and the result valid flag; the stack memories are not cleared.
// ----------------------------------------------------------------------------
// cursor_line_edit_buffer_top
// Gap buffer line editor: two character stacks either side of the cursor,
// with insert, cursor moves, backspace and indexed read.
// ----------------------------------------------------------------------------
module cursor_line_edit_buffer_top
	import clb_pkg::*;
#(
	parameter int CAPACITY = 256
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_axis_tvalid,
	output logic                   s_axis_tready,
	// ch [7:0], read_pos [15:8]
	input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
	// cmd [2:0]
	input  logic [CMD_W-1:0]       s_axis_tuser,
	output logic                   m_axis_tvalid,
	input  logic                   m_axis_tready,
	// read_char [7:0], text_length [16:8], cursor_pos [25:17], zeros above
	output logic [OUT_TDATA_W-1:0] m_axis_tdata,
	// status [1:0]
	output logic [ST_W-1:0]        m_axis_tuser
);

	localparam int CW = $clog2(CAPACITY + 1);
	localparam int AW = $clog2(CAPACITY);
	localparam int EW = (CW > LEN_W) ? CW : LEN_W;
	localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

	logic [CH_W-1:0] left_mem  [CAPACITY];
	logic [CH_W-1:0] right_mem [CAPACITY];

	logic [CW-1:0]    lc_q, rc_q, lc_n, rc_n, lc_d, rc_d, len_c, len_n;
	logic             accept;
	cmd_t             cmd;
	logic [CH_W-1:0]  ch;
	logic [EW-1:0]    pos_e, len_e, lc_e, ridx;
	logic             lwe, rwe, rd_ok_n, sel_left_n;
	logic [AW-1:0]    lwaddr, rwaddr, lraddr, rraddr, ltaddr, rtaddr;
	logic [CH_W-1:0]  lwdata, rwdata;
	status_t          status_n;
	logic [CW-1:0]    lc_dm1, rc_dm1;
	logic [EW-1:0]    len_ne, lc_ne;

	logic [CH_W-1:0]  l_top_q, r_top_q, l_rd_q, r_rd_q;
	logic             out_valid_q, rd_ok_q, sel_left_q;
	logic [LEN_W-1:0] out_len_q, out_cur_q;
	status_t          out_status_q;
	logic [CH_W-1:0]  read_char;

	assign s_axis_tready = !out_valid_q || m_axis_tready;
	assign accept        = s_axis_tvalid && s_axis_tready;
	assign cmd           = cmd_t'(s_axis_tuser);
	assign ch            = s_axis_tdata[CH_W-1:0];

	assign len_c = lc_q + rc_q;
	assign pos_e = EW'(s_axis_tdata[CH_W +: POS_W]);
	assign len_e = EW'(len_c);
	assign lc_e  = EW'(lc_q);
	assign ridx  = len_e - pos_e - EW'(1);

	assign lraddr = pos_e[AW-1:0];
	assign rraddr = ridx[AW-1:0];

	always_comb begin
		lc_n       = lc_q;
		rc_n       = rc_q;
		lwe        = 1'b0;
		rwe        = 1'b0;
		lwaddr     = lc_q[AW-1:0];
		rwaddr     = rc_q[AW-1:0];
		lwdata     = ch;
		rwdata     = l_top_q;
		status_n   = ST_OK;
		rd_ok_n    = 1'b0;
		sel_left_n = pos_e < lc_e;
		unique case (cmd)
			CMD_INSERT: begin
				if (len_c >= CAP_C) begin
					status_n = ST_FULL;
				end else begin
					lwe  = 1'b1;
					lc_n = lc_q + CW'(1);
				end
			end
			CMD_LEFT: begin
				if (lc_q != '0 && rc_q < CAP_C) begin
					lc_n = lc_q - CW'(1);
					rc_n = rc_q + CW'(1);
					rwe  = 1'b1;
				end
			end
			CMD_RIGHT: begin
				if (rc_q != '0 && lc_q < CAP_C) begin
					rc_n   = rc_q - CW'(1);
					lc_n   = lc_q + CW'(1);
					lwe    = 1'b1;
					lwdata = r_top_q;
				end
			end
			CMD_BACKSPACE: begin
				if (lc_q != '0)
					lc_n = lc_q - CW'(1);
			end
			CMD_READ: begin
				if (pos_e < len_e)
					rd_ok_n = 1'b1;
				else
					status_n = ST_PAST_END;
			end
			default: begin
			end
		endcase
		lwe = lwe && accept;
		rwe = rwe && accept;
	end

	assign lc_d   = accept ? lc_n : lc_q;
	assign rc_d   = accept ? rc_n : rc_q;
	assign lc_dm1 = lc_d - CW'(1);
	assign rc_dm1 = rc_d - CW'(1);
	assign ltaddr = lc_dm1[AW-1:0];
	assign rtaddr = rc_dm1[AW-1:0];
	assign len_n  = lc_n + rc_n;
	assign len_ne = EW'(len_n);
	assign lc_ne  = EW'(lc_n);

	// left stack: push/pop port, top-of-stack port with write bypass, indexed read
	always_ff @(posedge clk) begin
		if (lwe)
			left_mem[lwaddr] <= lwdata;
		if (accept)
			l_rd_q <= left_mem[lraddr];
		if (lwe && lwaddr == ltaddr)
			l_top_q <= lwdata;
		else
			l_top_q <= left_mem[ltaddr];
	end

	always_ff @(posedge clk) begin
		if (rwe)
			right_mem[rwaddr] <= rwdata;
		if (accept)
			r_rd_q <= right_mem[rraddr];
		if (rwe && rwaddr == rtaddr)
			r_top_q <= rwdata;
		else
			r_top_q <= right_mem[rtaddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lc_q        <= '0;
			rc_q        <= '0;
			out_valid_q <= 1'b0;
		end else begin
			lc_q <= lc_d;
			rc_q <= rc_d;
			if (accept)
				out_valid_q <= 1'b1;
			else if (m_axis_tready)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			out_len_q    <= len_ne[LEN_W-1:0];
			out_cur_q    <= lc_ne[LEN_W-1:0];
			out_status_q <= status_n;
			rd_ok_q      <= rd_ok_n;
			sel_left_q   <= sel_left_n;
		end
	end

	assign read_char     = !rd_ok_q ? '0 : (sel_left_q ? l_rd_q : r_rd_q);
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {{OUT_PAD_W{1'b0}}, out_cur_q, out_len_q, read_char};
	assign m_axis_tuser  = out_status_q;

`ifndef ASSERT_OFF
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(EW + 1)'(lc_q) + (EW + 1)'(rc_q) <= (EW + 1)'(CAPACITY))
		else $error("stack counts exceed capacity");

	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> out_valid_q)
		else $error("accepted command produced no result");

	a_stall_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !m_axis_tready) |-> !s_axis_tready)
		else $error("command taken while result stalled");

	a_left_move: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && cmd == CMD_LEFT && lc_q != '0) |=>
		(lc_q == $past(lc_q) - CW'(1) && rc_q == $past(rc_q) + CW'(1)))
		else $error("cursor left did not move one character across");

	a_insert_count: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && cmd == CMD_INSERT && len_c < CAP_C) |=>
		(lc_q == $past(lc_q) + CW'(1) && rc_q == $past(rc_q)))
		else $error("insert did not grow left stack by one");
`endif

endmodule

// File: bench/edit_buffer_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// edit_buffer_checker
// Watches both stream channels of the line edit buffer. Every command word
// taken is applied to a private gap buffer, and the expected result is
// queued. Every result word taken is checked field by field against the
// oldest queued result. Errors, outstanding results and the number of
// results checked are handed back to the bench top.
// ----------------------------------------------------------------------------
module edit_buffer_checker
	import clb_pkg::*;
#(
	parameter int CAPACITY = 256
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_axis_tvalid,
	input  logic                   s_axis_tready,
	input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
	input  logic [CMD_W-1:0]       s_axis_tuser,
	input  logic                   m_axis_tvalid,
	input  logic                   m_axis_tready,
	input  logic [OUT_TDATA_W-1:0] m_axis_tdata,
	input  logic [ST_W-1:0]        m_axis_tuser,
	output int                     errors,
	output int                     pending,
	output int                     compared
);

	typedef struct {
		logic [CH_W-1:0]  read_char;
		logic [LEN_W-1:0] text_length;
		logic [LEN_W-1:0] cursor_pos;
		status_t          status;
	} edit_result_t;

	logic [CH_W-1:0] before_cursor [CAPACITY];
	logic [CH_W-1:0] after_cursor [CAPACITY];
	int              n_before = 0;
	int              n_after = 0;
	edit_result_t    edit_results_due [$];

	initial begin
		errors = 0;
		pending = 0;
		compared = 0;
	end

	function automatic edit_result_t apply_edit(cmd_t op, logic [CH_W-1:0] ch,
		logic [POS_W-1:0] pos);
		edit_result_t r;
		int           k;
		r.read_char = '0;
		r.status = ST_OK;
		case (op)
			CMD_INSERT: begin
				if (n_before + n_after >= CAPACITY) begin
					r.status = ST_FULL;
				end else begin
					before_cursor[n_before] = ch;
					n_before++;
				end
			end
			CMD_LEFT: begin
				if (n_before > 0 && n_after < CAPACITY) begin
					n_before--;
					after_cursor[n_after] = before_cursor[n_before];
					n_after++;
				end
			end
			CMD_RIGHT: begin
				if (n_after > 0 && n_before < CAPACITY) begin
					n_after--;
					before_cursor[n_before] = after_cursor[n_after];
					n_before++;
				end
			end
			CMD_BACKSPACE: begin
				if (n_before > 0)
					n_before--;
			end
			CMD_READ: begin
				if (int'(pos) < n_before + n_after) begin
					if (int'(pos) < n_before) begin
						r.read_char = before_cursor[pos];
					end else begin
						// right stack top is the character just past the cursor
						k = int'(pos) - n_before;
						r.read_char = after_cursor[n_after - 1 - k];
					end
				end else begin
					r.status = ST_PAST_END;
				end
			end
			default: ;
		endcase
		r.text_length = LEN_W'(n_before + n_after);
		r.cursor_pos = LEN_W'(n_before);
		return r;
	endfunction

	function automatic void check_field(string name, int want, int got);
		if (want != got) begin
			errors++;
			$error("%s: expected %0d, got %0d", name, want, got);
		end
	endfunction

	always @(posedge clk) begin
		edit_result_t want;
		edit_result_t due;
		if (!arst_n) begin
			n_before = 0;
			n_after = 0;
			edit_results_due.delete();
		end else begin
			// results first: a word taken this edge belongs to an earlier command
			if (m_axis_tvalid && m_axis_tready) begin
				if (edit_results_due.size() == 0) begin
					errors++;
					$error("result word with no command outstanding: tdata %h tuser %h",
						m_axis_tdata, m_axis_tuser);
				end else begin
					want = edit_results_due.pop_front();
					compared++;
					check_field("read_char", want.read_char, m_axis_tdata[7:0]);
					check_field("text_length", want.text_length, m_axis_tdata[16:8]);
					check_field("cursor_pos", want.cursor_pos, m_axis_tdata[25:17]);
					check_field("padding", 0, m_axis_tdata[OUT_TDATA_W-1:26]);
					check_field("status", want.status, m_axis_tuser);
				end
			end
			if (s_axis_tvalid && s_axis_tready) begin
				due = apply_edit(cmd_t'(s_axis_tuser), s_axis_tdata[7:0],
					s_axis_tdata[15:8]);
				edit_results_due = {edit_results_due, due};
			end
		end
		pending = edit_results_due.size();
	end

endmodule

// File: bench/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives command words into the line edit buffer: a directed opening on an
// empty buffer, then random editing under four pacing phases, ending with
// the buffer filled to capacity. Checking is done by edit_buffer_checker.
// ----------------------------------------------------------------------------
module testbench;
	import clb_pkg::*;

	localparam int CAPACITY = 256;
	localparam int STALL_LIMIT = 2000;
	localparam int DRAIN_CYCLES = 8;
	localparam int RANDOM_PER_PHASE = 30;
	localparam logic [CMD_W-1:0] CMD_SPARE_FIRST = 3'd5;
	localparam logic [CMD_W-1:0] CMD_SPARE_LAST = 3'd7;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   s_axis_tvalid = 1'b0;
	logic                   s_axis_tready;
	logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
	logic [CMD_W-1:0]       s_axis_tuser = '0;
	logic                   m_axis_tvalid;
	logic                   m_axis_tready = 1'b0;
	logic [OUT_TDATA_W-1:0] m_axis_tdata;
	logic [ST_W-1:0]        m_axis_tuser;

	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int txt_len = 0;
	int txt_cur = 0;
	int words_sent = 0;
	int quiet_cycles = 0;
	int errors;
	int pending;
	int compared;

	cursor_line_edit_buffer_top #(.CAPACITY(CAPACITY)) uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	edit_buffer_checker #(.CAPACITY(CAPACITY)) u_check (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.errors        (errors),
		.pending       (pending),
		.compared      (compared)
	);

	initial begin
		forever #6 clk = ~clk;
	end

	always @(posedge clk) begin
		m_axis_tready <= arst_n && ($urandom_range(0, 99) >= recv_stall_pct);
	end

	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
			quiet_cycles <= 0;
		else if (arst_n)
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("watchdog: no word moved for %0d cycles", STALL_LIMIT);
			$display("TEST FAILED");
			$finish;
		end
	end

	// word: ch [7:0], read_pos [15:8]; cmd on tuser
	task automatic send_word(logic [CMD_W-1:0] op, logic [CH_W-1:0] ch,
		logic [POS_W-1:0] pos);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {pos, ch};
		s_axis_tuser <= op;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		words_sent++;
		// rough shadow of length and cursor, only to steer the stimulus
		case (op)
			CMD_INSERT: begin
				if (txt_len < CAPACITY) begin
					txt_len++;
					txt_cur++;
				end
			end
			CMD_LEFT: if (txt_cur > 0) txt_cur--;
			CMD_RIGHT: if (txt_cur < txt_len) txt_cur++;
			CMD_BACKSPACE: begin
				if (txt_cur > 0) begin
					txt_cur--;
					txt_len--;
				end
			end
			default: ;
		endcase
	endtask

	task automatic send_random_edit;
		int               r;
		logic [POS_W-1:0] pos;
		logic [CH_W-1:0]  ch;
		r = $urandom_range(0, 99);
		ch = CH_W'($urandom());
		if ($urandom_range(0, 9) < 6)
			pos = POS_W'($urandom_range(0, txt_len > 255 ? 255 : txt_len));
		else
			pos = POS_W'($urandom());
		if (r < 38)
			send_word(CMD_INSERT, ch, pos);
		else if (r < 53)
			send_word(CMD_LEFT, ch, pos);
		else if (r < 66)
			send_word(CMD_RIGHT, ch, pos);
		else if (r < 76)
			send_word(CMD_BACKSPACE, ch, pos);
		else if (r < 95)
			send_word(CMD_READ, ch, pos);
		else
			send_word(CMD_W'($urandom_range(CMD_SPARE_FIRST, CMD_SPARE_LAST)), ch, pos);
	endtask

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty buffer, then a short text with the cursor moved into it
		send_word(CMD_READ, 8'h00, 8'd0);
		send_word(CMD_LEFT, 8'h00, 8'd0);
		send_word(CMD_RIGHT, 8'h00, 8'd0);
		send_word(CMD_BACKSPACE, 8'h00, 8'd0);
		send_word(CMD_INSERT, "P", 8'd0);
		send_word(CMD_INSERT, "L", 8'd0);
		send_word(CMD_INSERT, "D", 8'd0);
		send_word(CMD_INSERT, 8'h00, 8'hff);
		send_word(CMD_INSERT, 8'hff, 8'h00);
		send_word(CMD_LEFT, 8'hff, 8'hff);
		send_word(CMD_LEFT, 8'h00, 8'h00);
		send_word(CMD_READ, 8'hff, 8'd0);
		send_word(CMD_READ, 8'h00, 8'd4);
		send_word(CMD_READ, 8'h00, 8'd3);
		send_word(CMD_READ, 8'h00, 8'd5);
		send_word(CMD_READ, 8'h00, 8'd255);
		send_word(CMD_BACKSPACE, 8'h00, 8'd0);
		send_word(CMD_INSERT, 8'ha5, 8'd0);
		send_word(CMD_RIGHT, 8'h00, 8'd0);
		send_word(CMD_RIGHT, 8'h00, 8'd0);
		send_word(CMD_RIGHT, 8'h00, 8'd0);
		send_word(CMD_SPARE_FIRST, 8'hff, 8'hff);
		send_word(CMD_SPARE_FIRST + 3'd1, 8'h5a, 8'd1);
		send_word(CMD_SPARE_LAST, 8'h00, 8'd2);
		send_word(CMD_READ, 8'h00, 8'd2);

		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 46; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 46; end
				default: begin send_idle_pct = 36; recv_stall_pct = 36; end
			endcase
			repeat (RANDOM_PER_PHASE)
				send_random_edit();
		end

		// cursor to the end, fill to capacity, overflow, then edit at capacity
		while (txt_cur < txt_len)
			send_word(CMD_RIGHT, CH_W'($urandom()), POS_W'($urandom()));
		while (txt_len < CAPACITY) begin
			send_word(CMD_INSERT, CH_W'($urandom()), POS_W'($urandom()));
			if ($urandom_range(0, 15) == 0)
				send_word(CMD_READ, CH_W'($urandom()), POS_W'($urandom_range(0, txt_len)));
		end
		repeat (3)
			send_word(CMD_INSERT, CH_W'($urandom()), POS_W'($urandom()));
		send_word(CMD_READ, 8'h00, 8'd255);
		send_word(CMD_READ, 8'h00, 8'd0);
		repeat (12)
			send_word(CMD_LEFT, CH_W'($urandom()), POS_W'($urandom()));
		repeat (4)
			send_word(CMD_READ, CH_W'($urandom()), POS_W'($urandom_range(240, 255)));
		send_word(CMD_INSERT, 8'h55, 8'd0);
		repeat (3)
			send_word(CMD_BACKSPACE, CH_W'($urandom()), POS_W'($urandom()));
		repeat (3)
			send_word(CMD_INSERT, CH_W'($urandom()), POS_W'($urandom()));
		send_word(CMD_READ, 8'h00, 8'd255);
		repeat (14)
			send_word(CMD_RIGHT, CH_W'($urandom()), POS_W'($urandom()));
		send_word(CMD_READ, 8'h00, 8'd255);
		s_axis_tvalid <= 1'b0;

		// let the checker count the last command as outstanding before waiting
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("%0d command words over four pacing phases, %0d result words checked",
			words_sent, compared);
		$display("empty and full buffer, cursor at both ends, reads in and past range, spare codes");
		if (errors == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
